[sv/cdsd_pkg.sv]
package cdsd_pkg;

	// Width of one packed BCD time field.
	localparam int FieldW = 8;

	// Number of time fields carried by one tick.
	localparam int NumFields = 6;

	// Width of a field index (pair or LED select).
	localparam int SelW = 3;

	// Width of the scan place as seen in the decode.
	localparam int PlaceXW = 4;

	// Number of enable lines on the display.
	localparam int EnableW = 5;

	// Left field shown when the right field is the last one.
	localparam logic [FieldW-1:0] LEFT_PAD = 8'h20;

	// Segment pattern of a blank digit.
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	// Select value that picks the last field as the right field.
	localparam logic [SelW-1:0] SEL_LAST = 3'd5;

	typedef logic [FieldW-1:0] field_t;
	typedef logic [NumFields*FieldW-1:0] fields_t;

	// Active-low seven-segment patterns for the digits zero to nine.
	function automatic logic [7:0] seg_decode(input logic [3:0] digit);
		logic [7:0] seg;
		unique case (digit)
			4'd0: seg = 8'h40;
			4'd1: seg = 8'h79;
			4'd2: seg = 8'h24;
			4'd3: seg = 8'h30;
			4'd4: seg = 8'h19;
			4'd5: seg = 8'h12;
			4'd6: seg = 8'h02;
			4'd7: seg = 8'h78;
			4'd8: seg = 8'h00;
			4'd9: seg = 8'h10;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

	// Field by index; an index past the last field reads as zero.
	function automatic field_t pick_field(input fields_t fields, input logic [PlaceXW-1:0] idx);
		field_t f;
		if (idx < 4'(NumFields)) begin
			f = fields[idx*FieldW +: FieldW];
		end else begin
			f = '0;
		end
		return f;
	endfunction

endpackage

[sv/clock_display_scan_driver.sv]
// Multiplexed clock display scan driver. Each input transfer is one scan tick: it carries
// the six packed BCD time fields and the two selects, and yields one output transfer with
// the segment byte (active low) and the active-low one-hot place enable for the current
// scan place, after which the place advances through NUM_DIGITS + 1 places and wraps.
// The digit places show the tens and units of the left and right fields of the chosen
// pair; the last place drives the LED bank with the inverted binary value of the LED
// field. One tick is accepted every cycle while the output is not stalled, and its result
// passes from the input register through the decode into the result register; a stalled
// output holds the result while one more tick waits in the input register.
module clock_display_scan_driver #(
	parameter int NUM_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sec_bcd[7:0], min_bcd[15:8], hour_bcd[23:16], month_bcd[31:24],
	// day_bcd[39:32], year_bcd[47:40]
	input  logic [47:0] s_tdata,
	// pair_select[2:0], led_select[5:3]
	input  logic [5:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// segment_bits[7:0], place_enable[12:8], zero fill[15:13]
	output logic [15:0] m_tdata,
	// place_index[2:0]
	output logic [2:0]  m_tuser
);

	localparam int PW = $clog2(NUM_DIGITS + 1);
	localparam logic [PW-1:0] PLACE_LAST = PW'(NUM_DIGITS);

	// Input register.
	logic                  valid_s1;
	cdsd_pkg::fields_t     fields_s1;
	logic [cdsd_pkg::SelW-1:0] psel_s1;
	logic [cdsd_pkg::SelW-1:0] lsel_s1;

	// Result register.
	logic                  valid_s2;
	logic [7:0]            seg_s2;
	logic [cdsd_pkg::EnableW-1:0] en_s2;
	logic [2:0]            index_s2;

	// Scan place.
	logic [PW-1:0]         place_q;

	logic                  load_s2;
	logic                  load_s1;

	// The result register takes a tick when it is empty or its result leaves now.
	assign load_s2  = !valid_s2 || m_tready;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) begin
			fields_s1 <= s_tdata;
			psel_s1   <= s_tuser[2:0];
			lsel_s1   <= s_tuser[5:3];
		end
	end

	// Decode of the current place.
	logic [cdsd_pkg::PlaceXW-1:0] place_x;
	logic [cdsd_pkg::PlaceXW-1:0] psel_x;
	cdsd_pkg::field_t             left_f;
	cdsd_pkg::field_t             right_f;
	cdsd_pkg::field_t             byte_f;
	cdsd_pkg::field_t             led_f;
	logic [3:0]                   digit;
	logic [7:0]                   led_val;
	logic [7:0]                   seg_d;
	logic [cdsd_pkg::EnableW-1:0] en_d;

	always_comb begin
		place_x = cdsd_pkg::PlaceXW'(place_q);
		psel_x  = cdsd_pkg::PlaceXW'(psel_s1);
		left_f  = (psel_s1 == cdsd_pkg::SEL_LAST) ? cdsd_pkg::LEFT_PAD :
			cdsd_pkg::pick_field(fields_s1, psel_x + 4'd1);
		right_f = cdsd_pkg::pick_field(fields_s1, psel_x);

		// Places zero and one take the left field, two and three the right one.
		unique case (place_x[3:1])
			3'd0:    byte_f = left_f;
			3'd1:    byte_f = right_f;
			default: byte_f = '0;
		endcase
		digit = place_x[0] ? byte_f[3:0] : {1'b0, byte_f[6:4]};

		// LED bank: binary value of the BCD field, tens masked to three bits.
		led_f   = cdsd_pkg::pick_field(fields_s1, cdsd_pkg::PlaceXW'(lsel_s1));
		led_val = 8'(led_f[3:0]) + 8'(led_f[6:4]) * 8'd10;

		if (place_q < PLACE_LAST) begin
			seg_d = cdsd_pkg::seg_decode(digit);
		end else begin
			seg_d = ~led_val;
		end

		for (int i = 0; i < cdsd_pkg::EnableW; i++) begin
			en_d[i] = (place_x != cdsd_pkg::PlaceXW'(i));
		end
	end

	// Result stage and scan advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			place_q  <= '0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				place_q <= (place_q == PLACE_LAST) ? '0 : place_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			seg_s2   <= seg_d;
			en_s2    <= en_d;
			index_s2 <= place_x[2:0];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, en_s2, seg_s2};
	assign m_tuser  = index_s2;

	// The scan place never leaves its range.
	a_place_range: assert property (@(posedge clk) disable iff (!arst_n)
		place_q <= PLACE_LAST)
		else $error("scan place out of range");

	// At most one place is enabled in a result.
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0(~en_s2))
		else $error("more than one place enabled");

	// A tick moving into the result register advances the scan place by one, with wrap.
	a_place_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && valid_s1) |=>
		(($past(place_q) == PLACE_LAST) ? (place_q == '0) : (place_q == $past(place_q) + 1'b1)))
		else $error("scan place did not advance");

	// The LED bank enable goes with the LED place index.
	a_led_place: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en_s2[4]) |-> (index_s2 == 3'd4))
		else $error("LED enable does not match place index");

endmodule
